FILE: src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is held
`define ADEC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("adpcm_dec check failed");

// clocked check that also runs through reset
`define ADEC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("adpcm_dec check failed");

`endif

FILE: src/adpcm_dec_pkg.sv
`default_nettype none

package adpcm_dec_pkg;

    // configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_COEFS_0_1    = 3'd0;
    localparam t_cfg_idx CFG_COEFS_2_3    = 3'd1;
    localparam t_cfg_idx CFG_COEFS_4_5    = 3'd2;
    localparam t_cfg_idx CFG_COEFS_6_7    = 3'd3;
    localparam t_cfg_idx CFG_INIT_HIST    = 3'd4;
    localparam t_cfg_idx CFG_SAMPLE_COUNT = 3'd5;

    localparam int CFG_DATA_W   = 64;
    localparam int FRAME_BYTES  = 8;
    localparam int BIF_W        = $clog2(FRAME_BYTES);
    localparam int FRAC_BITS    = 11;
    localparam int ACC_W        = 35;
    localparam int OUT_DEPTH    = 2;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1024);
    localparam logic signed [15:0]      PCM_MAX    = 16'sh7fff;
    localparam logic signed [15:0]      PCM_MIN    = -16'sh8000;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       stream_start;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] pcm_sample;
        logic               final_sample;
        logic               bad_predictor;
    } t_out_word;

endpackage

`default_nettype wire

FILE: src/dsp_adpcm_decoder_core.sv
// a byte accepted is held in the input register, its words reach o_out_data via the result queue
// flow: a header byte sets predictor and scale; data bytes give one sample a cycle while the queue
//   has room (single predictor multiply-add, the second sample needs the first as history)
// reset: synchronous active-low; histories, counters and config cleared, sample count 1,
//   the stream halted until a byte with stream_start
`default_nettype none

module dsp_adpcm_decoder_core (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // input words
    input  wire logic                                   i_in_valid,
    output      logic                                   o_in_ready,
    input  wire adpcm_dec_pkg::t_in_word                i_in_data,
    // result words
    output      logic                                   o_out_valid,
    input  wire logic                                   i_out_ready,
    output      adpcm_dec_pkg::t_out_word               o_out_data,
    // configuration writes
    input  wire logic                                   i_cfg_we,
    input  wire adpcm_dec_pkg::t_cfg_idx                i_cfg_idx,
    input  wire logic [adpcm_dec_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    // which nibble of the held byte is being worked on
    localparam logic PH_HIGH = 1'b0;
    localparam logic PH_LOW  = 1'b1;

    localparam int BIF_W = adpcm_dec_pkg::BIF_W;
    localparam int ACC_W = adpcm_dec_pkg::ACC_W;

    // configuration
    logic [63:0] r_coef [4];
    logic [31:0] r_init_hist;
    logic [31:0] r_count;

    // input holding register
    logic                    r_in_vld;
    adpcm_dec_pkg::t_in_word r_in;

    // decoder state
    logic               r_phase,  n_phase;
    logic signed [15:0] r_h1,     n_h1;
    logic signed [15:0] r_h2,     n_h2;
    logic        [2:0]  r_pred,   n_pred;
    logic        [3:0]  r_scale,  n_scale;
    logic [BIF_W-1:0]   r_bif,    n_bif;
    logic        [31:0] r_done,   n_done;
    logic               r_halted, n_halted;

    // result queue, two words so a new sample can go in while one waits
    adpcm_dec_pkg::t_out_word r_q [adpcm_dec_pkg::OUT_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic                     pop;
    logic                     room;
    logic                     push;
    logic                     consume;
    adpcm_dec_pkg::t_out_word push_word;

    // state as seen by this byte: a stream start reloads before anything else
    logic               start;
    logic signed [15:0] eff_h1;
    logic signed [15:0] eff_h2;
    logic [BIF_W-1:0]   eff_bif;
    logic        [31:0] eff_done;
    logic               eff_halted;

    // sample datapath
    logic        [3:0]       nib;
    logic [63:0]             coef_word;
    logic signed [15:0]      c1;
    logic signed [15:0]      c2;
    logic signed [31:0]      prod1;
    logic signed [31:0]      prod2;
    logic signed [ACC_W-1:0] resid;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] quot;
    logic signed [15:0]      pcm;
    logic                    count_ok;
    logic                    last;
    logic                    go;

    assign pop         = o_out_valid && i_out_ready;
    assign room        = (r_cnt < 2'(adpcm_dec_pkg::OUT_DEPTH)) || pop;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_q[r_rp];
    assign o_in_ready  = !r_in_vld || consume;

    assign start      = r_in_vld && (r_phase == PH_HIGH) && r_in.stream_start;
    assign eff_h1     = start ? $signed(r_init_hist[31:16]) : r_h1;
    assign eff_h2     = start ? $signed(r_init_hist[15:0])  : r_h2;
    assign eff_bif    = start ? '0    : r_bif;
    assign eff_done   = start ? '0    : r_done;
    assign eff_halted = start ? 1'b0  : r_halted;

    // coefficients of the frame's predictor, read live from the registers
    assign coef_word = r_coef[r_pred[2:1]];
    assign c1        = r_pred[0] ? coef_word[31:16] : coef_word[63:48];
    assign c2        = r_pred[0] ? coef_word[15:0]  : coef_word[47:32];

    // code scaled by 2^(scale+11), then the sum plus 1024 floored over 2048 (round half up) and clipped to 16 bits
    assign nib   = (r_phase == PH_LOW) ? r_in.code_byte[3:0] : r_in.code_byte[7:4];
    assign prod1 = c1 * eff_h1;
    assign prod2 = c2 * eff_h2;
    assign resid = ACC_W'($signed(nib)) <<< ({1'b0, r_scale} + 5'(adpcm_dec_pkg::FRAC_BITS));
    assign acc   = resid + ACC_W'(prod1) + ACC_W'(prod2) + adpcm_dec_pkg::ROUND_HALF;
    assign quot  = acc >>> adpcm_dec_pkg::FRAC_BITS;

    always_comb begin
        if (quot > ACC_W'(adpcm_dec_pkg::PCM_MAX)) begin
            pcm = adpcm_dec_pkg::PCM_MAX;
        end else if (quot < ACC_W'(adpcm_dec_pkg::PCM_MIN)) begin
            pcm = adpcm_dec_pkg::PCM_MIN;
        end else begin
            pcm = quot[15:0];
        end
    end

    assign count_ok  = eff_done < r_count;
    assign last      = (32'(eff_done + 32'd1) == r_count);

    // one step of the decoder per cycle unless its word has no room: header, high nibble, low nibble or dropped byte
    always_comb begin
        n_phase   = r_phase;
        n_h1      = eff_h1;
        n_h2      = eff_h2;
        n_pred    = r_pred;
        n_scale   = r_scale;
        n_bif     = eff_bif;
        n_done    = eff_done;
        n_halted  = eff_halted;
        consume   = 1'b0;
        push      = 1'b0;
        push_word = '0;

        if (r_in_vld) begin
            if (eff_halted) begin
                // dropped byte
                consume = 1'b1;
            end else if ((r_phase == PH_HIGH) && (eff_bif == '0)) begin
                consume = 1'b1;
                if (r_in.code_byte[7]) begin
                    // predictor out of range: one error word, then halt
                    push                    = 1'b1;
                    push_word.bad_predictor = 1'b1;
                    n_halted                = 1'b1;
                end else begin
                    n_pred  = r_in.code_byte[6:4];
                    n_scale = r_in.code_byte[3:0];
                    n_bif   = BIF_W'(1);
                end
            end else if (!count_ok) begin
                // count already reached, nothing more for this stream
                n_halted = 1'b1;
                consume  = 1'b1;
                n_bif    = eff_bif + BIF_W'(1);
                n_phase  = PH_HIGH;
            end else begin
                push                   = 1'b1;
                push_word.pcm_sample   = pcm;
                push_word.final_sample = last;
                n_h2                   = eff_h1;
                n_h1                   = pcm;
                n_done                 = 32'(eff_done + 32'd1);
                n_halted               = last;
                if (last || (r_phase == PH_LOW)) begin
                    // a final sample on the high nibble drops the low one
                    consume = 1'b1;
                    n_bif   = eff_bif + BIF_W'(1);
                    n_phase = PH_HIGH;
                end else begin
                    n_phase = PH_LOW;
                end
            end
        end

        // a word with nowhere to go holds the whole step back
        go = !push || room;
        if (!go) begin
            n_phase  = r_phase;
            n_h1     = r_h1;
            n_h2     = r_h2;
            n_pred   = r_pred;
            n_scale  = r_scale;
            n_bif    = r_bif;
            n_done   = r_done;
            n_halted = r_halted;
            consume  = 1'b0;
            push     = 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_coef[k] <= '0;
            end
            r_init_hist <= '0;
            r_count     <= 32'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                adpcm_dec_pkg::CFG_COEFS_0_1:    r_coef[0]   <= i_cfg_wdata;
                adpcm_dec_pkg::CFG_COEFS_2_3:    r_coef[1]   <= i_cfg_wdata;
                adpcm_dec_pkg::CFG_COEFS_4_5:    r_coef[2]   <= i_cfg_wdata;
                adpcm_dec_pkg::CFG_COEFS_6_7:    r_coef[3]   <= i_cfg_wdata;
                adpcm_dec_pkg::CFG_INIT_HIST:    r_init_hist <= i_cfg_wdata[31:0];
                adpcm_dec_pkg::CFG_SAMPLE_COUNT: r_count     <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // input holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_vld <= 1'b1;
        end else if (consume) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HIGH;
            r_h1     <= '0;
            r_h2     <= '0;
            r_pred   <= '0;
            r_scale  <= '0;
            r_bif    <= '0;
            r_done   <= '0;
            r_halted <= 1'b1;
        end else begin
            r_phase  <= n_phase;
            r_h1     <= n_h1;
            r_h2     <= n_h2;
            r_pred   <= n_pred;
            r_scale  <= n_scale;
            r_bif    <= n_bif;
            r_done   <= n_done;
            r_halted <= n_halted;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= push_word;
        end
    end

endmodule

`default_nettype wire

FILE: src/adpcm_dec_checker.sv
`default_nettype none
`include "assert_macros.svh"

module adpcm_dec_checker (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     o_in_ready,
    input wire logic                     o_out_valid,
    input wire logic                     i_out_ready,
    input wire adpcm_dec_pkg::t_out_word o_out_data
);

    // a stalled result word stays offered and unchanged
    `ADEC_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))

    // an error word carries no sample and no final mark
    `ADEC_ASSERT_ALWAYS(a_err_clean, i_clk, o_out_valid && o_out_data.bad_predictor |-> o_out_data.pcm_sample == 16'sd0 && !o_out_data.final_sample)

    // straight out of reset nothing is queued and the input side is open
    `ADEC_ASSERT(a_reset_idle, i_clk, i_rst_n, !$past(i_rst_n) |-> !o_out_valid && o_in_ready)

endmodule

bind dsp_adpcm_decoder_core adpcm_dec_checker u_adpcm_dec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_PHASES  = 24;
    localparam int PHASE_BYTES    = 58;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    // block ports, the inputs all driven from time zero
    logic                                 in_valid  = 1'b0;
    logic                                 in_ready;
    adpcm_dec_pkg::t_in_word              in_word   = '0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    adpcm_dec_pkg::t_out_word             out_word;
    logic                                 cfg_we    = 1'b0;
    adpcm_dec_pkg::t_cfg_idx              cfg_idx   = adpcm_dec_pkg::CFG_COEFS_0_1;
    logic [adpcm_dec_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // control shared between the stimulus and the clocked processes
    logic no_idle      = 1'b0;
    logic hold_request = 1'b0;

    // code bytes waiting for the driver, decoded words waiting for the block
    adpcm_dec_pkg::t_in_word  byte_queue[$];
    adpcm_dec_pkg::t_out_word samples_due[$];

    int mismatches   = 0;
    int quiet_cycles = 0;

    // decoder state as the testbench sees it
    logic [63:0]        coef_bank[4];
    logic [31:0]        hist_init;
    logic [31:0]        stream_len;
    logic signed [15:0] hist_one;
    logic signed [15:0] hist_two;
    logic [2:0]         cur_pred;
    logic [3:0]         cur_scale;
    logic [2:0]         byte_pos;
    logic [31:0]        samples_out;
    logic               stream_halted;

    dsp_adpcm_decoder_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // one nibble through the predictor; nothing comes out once the stream has halted
    // or the sample count has been used up
    function automatic void decode_nibble(logic [3:0] nib);
        logic [63:0]              bank;
        logic signed [15:0]       c1;
        logic signed [15:0]       c2;
        logic signed [3:0]        code;
        longint                   acc;
        longint                   q;
        adpcm_dec_pkg::t_out_word w;
        if (stream_halted) return;
        if (samples_out >= stream_len) begin
            // count reached or lowered under a running stream
            stream_halted = 1'b1;
            return;
        end
        bank = coef_bank[cur_pred[2:1]];
        c1   = cur_pred[0] ? bank[31:16] : bank[63:48];
        c2   = cur_pred[0] ? bank[15:0]  : bank[47:32];
        code = nib;
        acc  = longint'(code) <<< (cur_scale + 11);
        acc  = acc + longint'(c1) * longint'(hist_one) + longint'(c2) * longint'(hist_two)
             + 1024;
        // arithmetic shift floors towards minus infinity
        q = acc >>> 11;
        if (q > 32767)  q = 32767;
        if (q < -32768) q = -32768;
        hist_two    = hist_one;
        hist_one    = 16'(q);
        samples_out = samples_out + 1;
        w.pcm_sample    = 16'(q);
        w.final_sample  = (samples_out == stream_len);
        w.bad_predictor = 1'b0;
        samples_due.push_back(w);
        if (samples_out == stream_len) stream_halted = 1'b1;
    endfunction

    // one accepted code byte: restart, header or a pair of nibbles
    function automatic void decode_byte(adpcm_dec_pkg::t_in_word b);
        adpcm_dec_pkg::t_out_word w;
        if (b.stream_start) begin
            hist_one      = hist_init[31:16];
            hist_two      = hist_init[15:0];
            samples_out   = '0;
            byte_pos      = '0;
            stream_halted = 1'b0;
        end
        if (stream_halted) return;
        if (byte_pos == 0) begin
            if (b.code_byte[7]) begin
                // predictor 8 or above: one error word, then the stream stops
                w.pcm_sample    = '0;
                w.final_sample  = 1'b0;
                w.bad_predictor = 1'b1;
                samples_due.push_back(w);
                stream_halted = 1'b1;
                return;
            end
            cur_pred  = b.code_byte[6:4];
            cur_scale = b.code_byte[3:0];
            byte_pos  = 3'd1;
            return;
        end
        // high nibble first; if it completes the count the low one is dropped
        decode_nibble(b.code_byte[7:4]);
        decode_nibble(b.code_byte[3:0]);
        byte_pos = byte_pos + 3'd1;
    endfunction

    // configuration copy follows the same write edge as the block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            coef_bank  <= '{default: '0};
            hist_init  <= '0;
            stream_len <= 32'd1;
        end else if (cfg_we) begin
            case (cfg_idx)
                adpcm_dec_pkg::CFG_COEFS_0_1:    coef_bank[0] <= cfg_wdata;
                adpcm_dec_pkg::CFG_COEFS_2_3:    coef_bank[1] <= cfg_wdata;
                adpcm_dec_pkg::CFG_COEFS_4_5:    coef_bank[2] <= cfg_wdata;
                adpcm_dec_pkg::CFG_COEFS_6_7:    coef_bank[3] <= cfg_wdata;
                adpcm_dec_pkg::CFG_INIT_HIST:    hist_init    <= cfg_wdata[31:0];
                adpcm_dec_pkg::CFG_SAMPLE_COUNT: stream_len   <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // driver: decodes each word as it is taken, then offers the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid      <= 1'b0;
            in_word       <= '0;
            hist_one      = '0;
            hist_two      = '0;
            cur_pred      = '0;
            cur_scale     = '0;
            byte_pos      = '0;
            samples_out   = '0;
            stream_halted = 1'b1;
        end else begin
            if (in_valid && in_ready) decode_byte(in_word);
            if (!in_valid || in_ready) begin
                // about one cycle in nine left empty unless idling is off
                if (byte_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= 11)) begin
                    in_valid <= 1'b1;
                    in_word  <= byte_queue.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random back-pressure plus one long hold-off that fills the block
    int hold_left  = 0;
    logic hold_armed = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready  <= 1'b0;
            hold_left  <= 0;
            hold_armed <= 1'b0;
        end else if (hold_request && !hold_armed) begin
            hold_armed <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            out_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= no_idle || ($urandom_range(0, 99) >= 11);
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // monitor: every word taken is checked field by field against the oldest one due
    always @(posedge i_clk) begin : monitor
        adpcm_dec_pkg::t_out_word want;
        if (i_rst_n && out_valid && out_ready) begin
            if (samples_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word pcm=%0d final=%0b bad=%0b",
                    out_word.pcm_sample, out_word.final_sample, out_word.bad_predictor));
            end else begin
                want = samples_due.pop_front();
                if (out_word.pcm_sample !== want.pcm_sample)
                    report_mismatch($sformatf("pcm_sample got %0d want %0d",
                        out_word.pcm_sample, want.pcm_sample));
                if (out_word.final_sample !== want.final_sample)
                    report_mismatch($sformatf("final_sample got %b want %b",
                        out_word.final_sample, want.final_sample));
                if (out_word.bad_predictor !== want.bad_predictor)
                    report_mismatch($sformatf("bad_predictor got %b want %b",
                        out_word.bad_predictor, want.bad_predictor));
            end
        end
    end

    // watchdog: too long without any word moving on either side ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(input logic [7:0] b, input logic start);
        byte_queue.push_back(adpcm_dec_pkg::t_in_word'{code_byte: b, stream_start: start});
    endtask

    task automatic write_reg(input adpcm_dec_pkg::t_cfg_idx idx, input logic [63:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // wait until every byte is taken and every word is back, then let the block go quiet
    task automatic drain();
        do @(negedge i_clk);
        while (byte_queue.size() != 0 || in_valid || samples_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    adpcm_dec_pkg::t_cfg_idx coef_regs[4] = '{adpcm_dec_pkg::CFG_COEFS_0_1,
                                              adpcm_dec_pkg::CFG_COEFS_2_3,
                                              adpcm_dec_pkg::CFG_COEFS_4_5,
                                              adpcm_dec_pkg::CFG_COEFS_6_7};

    initial begin
        logic [63:0] bank;
        logic [15:0] coef;
        logic [7:0]  hdr;
        logic [31:0] count;
        int          queued;
        int          n;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // extremes of the coefficients and histories, a count that never runs out
        write_reg(adpcm_dec_pkg::CFG_COEFS_0_1, {16'h7fff, 16'h8000, 16'h1000, 16'hf800});
        write_reg(adpcm_dec_pkg::CFG_COEFS_2_3, {16'h8000, 16'h7fff, 16'h0800, 16'h0000});
        write_reg(adpcm_dec_pkg::CFG_COEFS_4_5, 64'hffff_ffff_ffff_ffff);
        write_reg(adpcm_dec_pkg::CFG_COEFS_6_7, 64'h0);
        write_reg(adpcm_dec_pkg::CFG_INIT_HIST, {32'h0, 16'h7fff, 16'h8000});
        write_reg(adpcm_dec_pkg::CFG_SAMPLE_COUNT, 64'h0000_0000_ffff_ffff);

        send(8'h35, 1'b0);                  // halted after reset, ignored
        send(8'h0f, 1'b1);                  // predictor 0, largest scale
        send(8'h78, 1'b0);                  // saturates both ways
        send(8'h00, 1'b0);
        send(8'hff, 1'b0);
        send(8'h87, 1'b0);
        send(8'h50, 1'b1);                  // restart part way through a frame
        send(8'hc3, 1'b0);
        send(8'h2d, 1'b0);
        send(8'he1, 1'b0);
        send(8'h6e, 1'b0);
        send(8'h0f, 1'b0);
        send(8'h3c, 1'b0);
        send(8'ha5, 1'b0);
        send(8'h1b, 1'b0);                  // next frame header, predictor 1
        send(8'h9a, 1'b0);
        send(8'hf0, 1'b1);                  // start on a bad predictor
        send(8'h11, 1'b0);                  // ignored while halted
        send(8'h7a, 1'b1);                  // predictor 7, all-zero coefficients
        send(8'h96, 1'b0);
        drain();

        // final word on a high nibble, the low nibble is dropped
        write_reg(adpcm_dec_pkg::CFG_SAMPLE_COUNT, 64'd3);
        send(8'h24, 1'b1);
        send(8'h31, 1'b0);
        send(8'h52, 1'b0);
        send(8'h77, 1'b0);
        drain();

        // count lowered beneath a running stream
        write_reg(adpcm_dec_pkg::CFG_SAMPLE_COUNT, 64'd100);
        send(8'h03, 1'b1);
        send(8'h11, 1'b0);
        send(8'h22, 1'b0);
        drain();
        write_reg(adpcm_dec_pkg::CFG_SAMPLE_COUNT, 64'd3);
        send(8'h33, 1'b0);
        send(8'h44, 1'b0);

        // random phases: mostly well-formed streams, some noise and bad headers
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            for (int k = 0; k < 4; k++) begin
                if (phase == 0 || $urandom_range(0, 1) == 0) begin
                    bank = '0;
                    for (int j = 0; j < 4; j++) begin
                        // realistic coefficients mostly, full range now and then
                        coef = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                             : 16'($urandom_range(0, 8191)) - 16'd4096;
                        bank = {bank[47:0], coef};
                    end
                    write_reg(coef_regs[k], bank);
                end
            end
            if (phase == 0 || $urandom_range(0, 2) == 0)
                write_reg(adpcm_dec_pkg::CFG_INIT_HIST, 64'($urandom));
            case ($urandom_range(0, 9))
                0:       count = 32'd1;
                1:       count = 32'hffff_ffff;
                2, 3:    count = 32'($urandom_range(200, 3000));
                default: count = 32'($urandom_range(2, 60));
            endcase
            write_reg(adpcm_dec_pkg::CFG_SAMPLE_COUNT, 64'(count));

            no_idle = (phase == 6);
            if (phase == 12) hold_request = 1'b1;

            queued = 0;
            while (queued < PHASE_BYTES) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise burst
                    n = $urandom_range(1, 6);
                    repeat (n) send(8'($urandom), $urandom_range(0, 3) == 0);
                end else begin
                    n = $urandom_range(1, 40);
                    for (int j = 0; j < n; j++) begin
                        if (j % adpcm_dec_pkg::FRAME_BYTES == 0) begin
                            hdr = {($urandom_range(0, 24) == 0) ? 4'($urandom_range(8, 15))
                                                                : 4'($urandom_range(0, 7)),
                                   4'($urandom)};
                            send(hdr, j == 0);
                        end else begin
                            send(8'($urandom), 1'b0);
                        end
                    end
                end
                queued += n;
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/adpcm_dec_pkg.sv
src/dsp_adpcm_decoder_core.sv
src/adpcm_dec_checker.sv
test/testbench.sv
